@@ rtl/rc4_pkg.sv @@
// shared types and constants for the rc4 stream cipher block
package rc4_pkg;

  localparam int unsigned MAX_KEY_BYTES = 16;
  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned KEY_IDX_W     = 4;
  localparam int unsigned KEY_LEN_W     = 5;
  localparam int unsigned CFG_ADDR_W    = 5;
  localparam int unsigned CFG_DATA_W    = 64;

  localparam logic [63:0]        KEY_LOW_RESET  = 64'd7104119;
  localparam logic [63:0]        KEY_HIGH_RESET = 64'd0;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd3;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_message;
    logic       last_of_message;
  } rc4_in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       last_byte;
  } rc4_out_t;

  typedef struct packed {
    logic       clr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } rc4_ram_ctrl_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } rc4_add_ops_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_INIT,
    ST_KS_RD_N,
    ST_KS_RD_J,
    ST_KS_WR_N,
    ST_KS_WR_J,
    ST_PR_RD_I,
    ST_PR_RD_J,
    ST_PR_WR_I,
    ST_PR_WR_J,
    ST_PR_RD_T,
    ST_PR_OUT
  } rc4_state_t;

endpackage

@@ rtl/rc4_perm_ram.sv @@
// 256 x 8 permutation memory, one write and one registered read port, identity when not valid
module rc4_perm_ram (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rc4_pkg::rc4_ram_ctrl_t ctrl,
  output logic [7:0]             rd_data
);

  logic [7:0]                     mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0] valid_r;
  logic [7:0]                     rd_data_r;

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= ctrl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      valid_r <= '0;
    end else if (ctrl.we) begin
      valid_r[ctrl.waddr] <= 1'b1;
    end
  end

  // entry not yet written since the last clear reads as its own address
  always_ff @(posedge clk) begin
    rd_data_r <= valid_r[ctrl.raddr] ? mem[ctrl.raddr] : ctrl.raddr;
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/rc4_add_unit.sv @@
// shared three-operand byte adder, modulo 256
module rc4_add_unit (
  input  rc4_pkg::rc4_add_ops_t ops,
  output logic [7:0]            sum
);

  logic [9:0] full_sum;

  assign full_sum = {2'b00, ops.a} + {2'b00, ops.b} + {2'b00, ops.c};
  assign sum      = full_sum[7:0];

endmodule

@@ rtl/rc4_stream_cipher_core.sv @@
// top level of the rc4 stream cipher: config registers, sequencer, output register
// an ordinary byte passes the read i, read j, write i, write j, read t and output states
// a first-of-message byte first runs the init state and 256 key schedule steps (read n, read j, write n, write j)
// only one byte at a time: a new one is taken in idle once the previous result is registered
// reset: synchronous active low, permutation reads as identity at once (valid bits cleared),
// indices zero, key registers to their defaults, no clearing pass
module rc4_stream_cipher_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rc4_pkg::rc4_in_t                    in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output rc4_pkg::rc4_out_t                   out_data,
  // apb-style configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [rc4_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  // configuration registers
  logic [63:0]                     key_low_r;
  logic [63:0]                     key_high_r;
  logic [rc4_pkg::KEY_LEN_W-1:0]   key_len_r;
  logic                            cfg_wr;
  logic [1:0]                      cfg_idx;

  // sequencer and datapath
  rc4_pkg::rc4_state_t             state_r, state_nxt;
  logic [7:0]                      i_r, i_nxt;
  logic [7:0]                      j_r, j_nxt;
  logic [7:0]                      si_r, si_nxt;
  logic [7:0]                      sj_r, sj_nxt;
  logic [7:0]                      t_r, t_nxt;
  logic [rc4_pkg::KEY_IDX_W-1:0]   kidx_r, kidx_nxt;
  logic [7:0]                      data_r;
  logic                            last_r;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  rc4_pkg::rc4_out_t               out_data_r, out_data_nxt;

  rc4_pkg::rc4_ram_ctrl_t          ram_ctrl;
  logic [7:0]                      rd_data;
  rc4_pkg::rc4_add_ops_t           add_ops;
  logic [7:0]                      add_sum;

  logic                            in_take;
  logic                            out_free;
  logic [127:0]                    key_all;
  logic [7:0]                      key_byte;
  logic [rc4_pkg::KEY_LEN_W-1:0]   len_used;
  logic [rc4_pkg::KEY_LEN_W-1:0]   kidx_inc;

  // ---------------------------------------------------------------------------
  // configuration port, writes land on the access phase, pready tied high
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= rc4_pkg::KEY_LOW_RESET;
      key_high_r <= rc4_pkg::KEY_HIGH_RESET;
      key_len_r  <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rc4_pkg::REG_KEY_LOW:  key_low_r  <= pwdata;
        rc4_pkg::REG_KEY_HIGH: key_high_r <= pwdata;
        rc4_pkg::REG_KEY_LEN:  key_len_r  <= pwdata[rc4_pkg::KEY_LEN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rc4_pkg::REG_KEY_LOW:  prdata = key_low_r;
      rc4_pkg::REG_KEY_HIGH: prdata = key_high_r;
      rc4_pkg::REG_KEY_LEN:  prdata = {{(rc4_pkg::CFG_DATA_W-rc4_pkg::KEY_LEN_W){1'b0}},
                                       key_len_r};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // key byte selection: zero length behaves as one, long keys saturate
  // ---------------------------------------------------------------------------
  assign key_all  = {key_high_r, key_low_r};
  assign key_byte = key_all[{kidx_r, 3'b000} +: 8];

  always_comb begin
    if (key_len_r == '0) begin
      len_used = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_len_r > rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES)) begin
      len_used = rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES);
    end else begin
      len_used = key_len_r;
    end
  end

  assign kidx_inc = {1'b0, kidx_r} + rc4_pkg::KEY_LEN_W'(1);

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == rc4_pkg::ST_IDLE);
  assign in_take   = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // shared memory and adder
  // ---------------------------------------------------------------------------
  rc4_perm_ram u_perm_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ram_ctrl),
    .rd_data (rd_data)
  );

  rc4_add_unit u_add_unit (
    .ops (add_ops),
    .sum (add_sum)
  );

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = in_data.first_of_message ? rc4_pkg::ST_KS_INIT : rc4_pkg::ST_PR_RD_I;
        end
      end
      rc4_pkg::ST_KS_INIT: state_nxt = rc4_pkg::ST_KS_RD_N;
      rc4_pkg::ST_KS_RD_N: state_nxt = rc4_pkg::ST_KS_RD_J;
      rc4_pkg::ST_KS_RD_J: state_nxt = rc4_pkg::ST_KS_WR_N;
      rc4_pkg::ST_KS_WR_N: state_nxt = rc4_pkg::ST_KS_WR_J;
      rc4_pkg::ST_KS_WR_J: begin
        state_nxt = (i_r == 8'hFF) ? rc4_pkg::ST_PR_RD_I : rc4_pkg::ST_KS_RD_N;
      end
      rc4_pkg::ST_PR_RD_I: state_nxt = rc4_pkg::ST_PR_RD_J;
      rc4_pkg::ST_PR_RD_J: state_nxt = rc4_pkg::ST_PR_WR_I;
      rc4_pkg::ST_PR_WR_I: state_nxt = rc4_pkg::ST_PR_WR_J;
      rc4_pkg::ST_PR_WR_J: state_nxt = rc4_pkg::ST_PR_RD_T;
      rc4_pkg::ST_PR_RD_T: state_nxt = rc4_pkg::ST_PR_OUT;
      rc4_pkg::ST_PR_OUT: begin
        if (out_free) begin
          state_nxt = rc4_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rc4_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs: memory control, adder operands, register next values
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_ctrl      = '0;
    add_ops       = '0;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    kidx_nxt      = kidx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      rc4_pkg::ST_IDLE: ;
      rc4_pkg::ST_KS_INIT: begin
        // fresh schedule starts from identity with both indices cleared
        ram_ctrl.clr = 1'b1;
        i_nxt        = '0;
        j_nxt        = '0;
        kidx_nxt     = '0;
      end
      rc4_pkg::ST_KS_RD_N: begin
        ram_ctrl.raddr = i_r;
      end
      rc4_pkg::ST_KS_RD_J: begin
        // j += S[n] + key[n mod len], fetch S[j]
        add_ops.a      = j_r;
        add_ops.b      = rd_data;
        add_ops.c      = key_byte;
        si_nxt         = rd_data;
        j_nxt          = add_sum;
        ram_ctrl.raddr = add_sum;
        kidx_nxt       = (kidx_inc == len_used) ? '0 : kidx_inc[rc4_pkg::KEY_IDX_W-1:0];
      end
      rc4_pkg::ST_KS_WR_N: begin
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = i_r;
        ram_ctrl.wdata = rd_data;
      end
      rc4_pkg::ST_KS_WR_J: begin
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = j_r;
        ram_ctrl.wdata = si_r;
        add_ops.a      = i_r;
        add_ops.c      = 8'd1;
        i_nxt          = add_sum;  // wraps to zero after the last step
        if (i_r == 8'hFF) begin
          j_nxt = '0;
        end
      end
      rc4_pkg::ST_PR_RD_I: begin
        add_ops.a      = i_r;
        add_ops.c      = 8'd1;
        i_nxt          = add_sum;
        ram_ctrl.raddr = add_sum;
      end
      rc4_pkg::ST_PR_RD_J: begin
        add_ops.a      = j_r;
        add_ops.b      = rd_data;
        si_nxt         = rd_data;
        j_nxt          = add_sum;
        ram_ctrl.raddr = add_sum;
      end
      rc4_pkg::ST_PR_WR_I: begin
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = i_r;
        ram_ctrl.wdata = rd_data;
        sj_nxt         = rd_data;
      end
      rc4_pkg::ST_PR_WR_J: begin
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = j_r;
        ram_ctrl.wdata = si_r;
      end
      rc4_pkg::ST_PR_RD_T: begin
        // both swap writes have landed, so the plain read sees the new table
        add_ops.a      = si_r;
        add_ops.b      = sj_r;
        t_nxt          = add_sum;
        ram_ctrl.raddr = add_sum;
      end
      rc4_pkg::ST_PR_OUT: begin
        // keep re-reading S[t] while the output register is still occupied
        ram_ctrl.raddr = t_r;
        if (out_free) begin
          out_data_nxt.result_byte = data_r ^ rd_data;
          out_data_nxt.last_byte   = last_r;
          out_valid_nxt            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scratch registers, no reset needed
  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    kidx_r     <= kidx_nxt;
    out_data_r <= out_data_nxt;
    if (in_take) begin
      data_r <= in_data.data_byte;
      last_r <= in_data.last_of_message;
    end
  end

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the rc4 stream cipher core, with a predictor and random traffic
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any transaction before the run is declared hung
  // worst case: a key schedule, a long receiver stall and a sender gap
  localparam int unsigned HANG_LIMIT = 8000;
  // cycles allowed for the block to settle once the last result has left
  localparam int unsigned SETTLE_CYCLES = 8;
  // register slot beyond the list, writes to it must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_BYTES = 305;

  typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG_STALL} rx_mode_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rc4_pkg::rc4_in_t in_data;
  logic out_valid;
  logic out_ready;
  rc4_pkg::rc4_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rc4_pkg::CFG_ADDR_W-1:0] paddr;
  logic [rc4_pkg::CFG_DATA_W-1:0] pwdata;
  logic [rc4_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // predictor state: permutation, indices and a shadow of the key registers
  logic [7:0] cipher_perm [rc4_pkg::PERM_DEPTH];
  logic [7:0] cipher_i;
  logic [7:0] cipher_j;
  logic [63:0] key_lo_q;
  logic [63:0] key_hi_q;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_q;

  // bytes predicted but not yet seen on the result channel
  rc4_pkg::rc4_out_t cipher_bytes_due [$];
  int unsigned fail_count = 0;

  // sender idling state
  int unsigned burst_left = 0;
  bit steady_sender = 1'b0;

  rc4_stream_cipher_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // key byte n of the 16-byte key, low register holds bytes 0 to 7
  function automatic logic [7:0] key_byte_at(int unsigned n);
    int unsigned k;
    k = n % rc4_pkg::MAX_KEY_BYTES;
    if (k < 8) begin
      return key_lo_q[8*k +: 8];
    end
    return key_hi_q[8*(k-8) +: 8];
  endfunction

  function automatic void reset_permutation();
    for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
      cipher_perm[n] = n[7:0];
    end
    cipher_i = '0;
    cipher_j = '0;
  endfunction

  // standard key schedule, length zero counts as one and long keys saturate
  function automatic void rerun_key_schedule();
    int unsigned len;
    logic [7:0] j;
    logic [7:0] tmp;
    len = key_len_q;
    if (len < 1) begin
      len = 1;
    end
    if (len > rc4_pkg::MAX_KEY_BYTES) begin
      len = rc4_pkg::MAX_KEY_BYTES;
    end
    reset_permutation();
    j = '0;
    for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
      j = j + cipher_perm[n] + key_byte_at(n % len);
      tmp = cipher_perm[n];
      cipher_perm[n] = cipher_perm[j];
      cipher_perm[j] = tmp;
    end
  endfunction

  // advance the cipher by one byte and return the result it should give
  function automatic rc4_pkg::rc4_out_t predict_cipher(rc4_pkg::rc4_in_t item);
    rc4_pkg::rc4_out_t res;
    logic [7:0] tmp;
    logic [7:0] sum;
    if (item.first_of_message) begin
      rerun_key_schedule();
    end
    cipher_i = cipher_i + 8'd1;
    cipher_j = cipher_j + cipher_perm[cipher_i];
    tmp = cipher_perm[cipher_i];
    cipher_perm[cipher_i] = cipher_perm[cipher_j];
    cipher_perm[cipher_j] = tmp;
    sum = cipher_perm[cipher_i] + cipher_perm[cipher_j];
    res.result_byte = item.data_byte ^ cipher_perm[sum];
    res.last_byte = item.last_of_message;
    return res;
  endfunction

  function automatic void apply_key_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      rc4_pkg::REG_KEY_LOW: begin
        key_lo_q = val;
      end
      rc4_pkg::REG_KEY_HIGH: begin
        key_hi_q = val;
      end
      rc4_pkg::REG_KEY_LEN: begin
        key_len_q = val[rc4_pkg::KEY_LEN_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [63:0] key_reg_value(logic [1:0] idx);
    case (idx)
      rc4_pkg::REG_KEY_LOW: return key_lo_q;
      rc4_pkg::REG_KEY_HIGH: return key_hi_q;
      default: return 64'(key_len_q);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking, oldest prediction first
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cipher_bytes_due.size() == 0) begin
        $error("result transaction with nothing outstanding: result_byte %0h",
               out_data.result_byte);
        fail_count++;
      end else begin
        rc4_pkg::rc4_out_t want;
        want = cipher_bytes_due.pop_front();
        if (out_data.result_byte !== want.result_byte) begin
          $error("result_byte mismatch: expected %0h, actual %0h",
                 want.result_byte, out_data.result_byte);
          fail_count++;
        end
        if (out_data.last_byte !== want.last_byte) begin
          $error("last_byte mismatch: expected %0b, actual %0b",
                 want.last_byte, out_data.last_byte);
          fail_count++;
        end
      end
    end
  end

  // hang detection: any transaction on either channel restarts the count
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // receiver back-pressure, switching between its own patterns
  initial begin
    rx_mode_t mode;
    int unsigned span;
    int unsigned period;
    int unsigned stall_len;
    int unsigned stall_left;
    int unsigned tick;
    out_ready = 1'b0;
    stall_left = 0;
    tick = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(50, 400);
      period = $urandom_range(2, 12);
      stall_len = $urandom_range(1, period - 1);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          RX_OPEN: begin
            out_ready <= 1'b1;
          end
          RX_RANDOM: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
          RX_PERIODIC: begin
            out_ready <= ((tick % period) >= stall_len);
          end
          default: begin
            // mostly open, with an occasional long stall
            if (stall_left > 0) begin
              stall_left--;
              out_ready <= 1'b0;
            end else if ($urandom_range(0, 60) == 0) begin
              stall_left = $urandom_range(10, 40);
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared stimulus tasks
  // ---------------------------------------------------------------------------

  // one input transaction, the sender idles between bursts unless told to stay steady
  task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
    rc4_pkg::rc4_in_t item;
    int unsigned gap;
    item.data_byte = data;
    item.first_of_message = first;
    item.last_of_message = last;
    if (!steady_sender && burst_left == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    cipher_bytes_due.insert(cipher_bytes_due.size(), predict_cipher(item));
  endtask

  // hold off the sender until every predicted byte has come back, then let the block settle
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cipher_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write, setup then access phase, followed by a read back of listed registers
  task automatic write_key_reg(input logic [1:0] idx, input logic [63:0] val);
    logic [63:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rc4_pkg::CFG_ADDR_W'({idx, 3'b000});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    apply_key_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx != REG_UNUSED) begin
      want = key_reg_value(idx);
      @(negedge clk);
      psel <= 1'b1;
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (pready !== 1'b1) @(posedge clk);
      if (prdata !== want) begin
        $error("register %0d read back mismatch: expected %0h, actual %0h", idx, want, prdata);
        fail_count++;
      end
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi, input logic [63:0] len);
    write_key_reg(rc4_pkg::REG_KEY_LOW, lo);
    write_key_reg(rc4_pkg::REG_KEY_HIGH, hi);
    write_key_reg(rc4_pkg::REG_KEY_LEN, len);
  endtask

  // a complete message of random bytes, flags on the first and final byte
  task automatic send_message(input int unsigned len);
    for (int unsigned n = 0; n < len; n++) begin
      send_byte(8'($urandom), n == 0, n == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // keystream straight from the reset state, no key schedule yet
  task automatic test_unkeyed_stream();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    wait_for_results();
  endtask

  // default key from reset, also a first byte arriving mid-message
  task automatic test_reset_key();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b1);
    wait_for_results();
  endtask

  // key length of zero, one, full, saturated, plus masking and an unlisted register
  task automatic test_key_limits();
    load_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd16);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    wait_for_results();
    load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd0);
    send_byte(8'h3C, 1'b1, 1'b1);
    send_byte(8'hC3, 1'b1, 1'b1);
    wait_for_results();
    write_key_reg(rc4_pkg::REG_KEY_LEN, 64'd31);
    send_byte(8'h81, 1'b1, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b1);
    wait_for_results();
    load_key(64'd0, 64'd0, 64'd1);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    wait_for_results();
    // only the low five bits of the length register hold
    write_key_reg(rc4_pkg::REG_KEY_LOW, 64'h8000_0000_0000_0001);
    write_key_reg(rc4_pkg::REG_KEY_LEN, 64'hFFFF_FFFF_FFFF_FFE5);
    write_key_reg(REG_UNUSED, 64'hDEAD_BEEF_CAFE_F00D);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1);
    wait_for_results();
  endtask

  // phases of random keys and traffic, mostly well-formed messages
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [63:0] len_sel;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady_sender = (phase % 4 == 3);
      case ($urandom_range(0, 5))
        0: len_sel = 64'd0;
        1: len_sel = 64'd1;
        2: len_sel = 64'(rc4_pkg::MAX_KEY_BYTES);
        3: len_sel = {$urandom, $urandom};
        default: len_sel = 64'($urandom_range(1, rc4_pkg::MAX_KEY_BYTES));
      endcase
      load_key({$urandom, $urandom}, {$urandom, $urandom}, len_sel);
      if ($urandom_range(0, 3) == 0) begin
        write_key_reg(REG_UNUSED, {$urandom, $urandom});
      end
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          // long messages now and then so that the indices wrap
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 24);
        end else if (pick == 8) begin
          len = $urandom_range(1, 20);
        end else begin
          len = $urandom_range(1, 10);
        end
        // keep each phase to its byte budget
        if (len > PHASE_BYTES - sent) begin
          len = PHASE_BYTES - sent;
        end
        if (pick < 8) begin
          send_message(len);
        end else if (pick == 8) begin
          // noise: flags anywhere
          for (int unsigned n = 0; n < len; n++) begin
            send_byte(8'($urandom), $urandom_range(0, 11) == 0, $urandom_range(0, 3) == 0);
          end
        end else begin
          // broken: a message cut short, or bytes carried on with no first flag
          for (int unsigned n = 0; n < len; n++) begin
            send_byte(8'($urandom), (n == 0) && $urandom_range(0, 1), 1'b0);
          end
        end
        sent += len;
        // hold off the sender until all results are back
        if ((phase == 0 && sent > PHASE_BYTES / 2 && sent - len <= PHASE_BYTES / 2) ||
            $urandom_range(0, 40) == 0) begin
          wait_for_results();
        end
      end
      wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    reset_permutation();
    key_lo_q = rc4_pkg::KEY_LOW_RESET;
    key_hi_q = rc4_pkg::KEY_HIGH_RESET;
    key_len_q = rc4_pkg::KEY_LEN_RESET;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_unkeyed_stream();
    test_reset_key();
    test_key_limits();
    test_random_traffic();

    wait_for_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
